FILE: rtl/core/bpd_pkg.sv
// Shared types, constants and helpers for the byte pair text decompressor.
`timescale 1ns / 1ps
package bpd_pkg;

	// default sizing
	localparam int STACK_DEPTH_DEF = 2048;
	localparam int MAX_RUN_DEF     = 64;

	// pair table: 128 entries, each a first and a second byte
	localparam int PAIR_ENTRIES = 128;
	localparam int PAIR_AW      = $clog2(PAIR_ENTRIES);

	// result status codes
	localparam logic [1:0] STAT_DATA = 2'd0;
	localparam logic [1:0] STAT_END  = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	// characters rewritten on output
	localparam logic [6:0] CHAR_TAB   = 7'd9;
	localparam logic [6:0] CHAR_LF    = 7'd10;
	localparam logic [6:0] CHAR_CR    = 7'd13;
	localparam logic [6:0] CHAR_SPACE = 7'd32;

	// pair table access from the sequencer
	typedef struct packed {
		logic               clear;
		logic               we;
		logic [7:0]         waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [PAIR_AW-1:0] raddr;
	} tbl_req_t;

	// one pair entry as read back
	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
	} pair_t;

	// carriage return -> line feed, tab -> space
	function automatic logic [6:0] convert(input logic [6:0] c);
		logic [6:0] r;
		r = c;
		if (c == CHAR_CR) begin
			r = CHAR_LF;
		end else if (c == CHAR_TAB) begin
			r = CHAR_SPACE;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/bpd_in_if.sv
// Input channel: one compressed file byte per word.
`timescale 1ns / 1ps
interface bpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_file;

	modport source (output valid, output in_byte, output start_of_file, input ready);
	modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

FILE: rtl/core/bpd_out_if.sv
// Output channel: one decoded text byte or status per word.
`timescale 1ns / 1ps
interface bpd_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

FILE: rtl/core/bpd_pair_table.sv
// Pair table: two 128 x 8 memories with per-entry valid bits, cleared per file.
`timescale 1ns / 1ps
module bpd_pair_table (
	input  logic              clk,
	input  logic              arst_n,
	input  bpd_pkg::tbl_req_t req,
	output bpd_pkg::pair_t    rd_pair
);

	logic [7:0] first_mem  [bpd_pkg::PAIR_ENTRIES];
	logic [7:0] second_mem [bpd_pkg::PAIR_ENTRIES];

	logic [bpd_pkg::PAIR_ENTRIES-1:0] first_vld_q;
	logic [bpd_pkg::PAIR_ENTRIES-1:0] second_vld_q;

	logic [7:0] first_rd_q;
	logic [7:0] second_rd_q;
	logic       first_ok_q;
	logic       second_ok_q;

	logic [bpd_pkg::PAIR_AW-1:0] wentry;
	logic                        whalf;

	// even load index -> first byte, odd -> second byte
	assign wentry = req.waddr[bpd_pkg::PAIR_AW:1];
	assign whalf  = req.waddr[0];

	// valid bits and their read registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vld_q  <= '0;
			second_vld_q <= '0;
			first_ok_q   <= 1'b0;
			second_ok_q  <= 1'b0;
		end else begin
			if (req.clear) begin
				first_vld_q  <= '0;
				second_vld_q <= '0;
			end else if (req.we) begin
				if (whalf) begin
					second_vld_q[wentry] <= 1'b1;
				end else begin
					first_vld_q[wentry] <= 1'b1;
				end
			end
			if (req.re) begin
				first_ok_q  <= first_vld_q[req.raddr];
				second_ok_q <= second_vld_q[req.raddr];
			end
		end
	end

	// storage, registered read
	always_ff @(posedge clk) begin
		if (req.we && !whalf) begin
			first_mem[wentry] <= req.wdata;
		end
		if (req.re) begin
			first_rd_q <= first_mem[req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we && whalf) begin
			second_mem[wentry] <= req.wdata;
		end
		if (req.re) begin
			second_rd_q <= second_mem[req.raddr];
		end
	end

	// unloaded entries read as zero
	assign rd_pair.first  = first_ok_q ? first_rd_q : 8'd0;
	assign rd_pair.second = second_ok_q ? second_rd_q : 8'd0;

endmodule

FILE: rtl/core/bpd_seq.sv
// Sequencer: file phase, expansion stack, run buffer and output register.
`timescale 1ns / 1ps
module bpd_seq #(
	parameter int STACK_DEPTH = bpd_pkg::STACK_DEPTH_DEF,
	parameter int MAX_RUN     = bpd_pkg::MAX_RUN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bpd_in_if.sink            byte_in,
	bpd_out_if.source         text_out,
	output bpd_pkg::tbl_req_t tbl_req,
	input  bpd_pkg::pair_t    tbl_pair
);

	localparam int TW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int NW  = $clog2(MAX_RUN + 1);
	localparam int BAW = $clog2(MAX_RUN);

	localparam logic [TW-1:0] TOP_LIMIT = TW'(STACK_DEPTH - 2);
	localparam logic [NW-1:0] RUN_LIMIT = NW'(MAX_RUN);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LOAD,
		PH_DECODE,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RESULT,
		S_EVAL,
		S_PAIR,
		S_POPW,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	state_t  state_q;
	phase_t  phase_q;
	phase_t  eff_phase;

	logic [7:0]    byte_q;
	logic          sof_q;
	logic [7:0]    pair_left_q;
	logic [7:0]    load_idx_q;
	logic [7:0]    c_q;
	logic [TW-1:0] top_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] idx_q;
	logic [6:0]    res_byte_q;
	logic [1:0]    res_stat_q;

	logic          out_valid_q;
	logic [6:0]    out_byte_q;
	logic [1:0]    out_stat_q;
	logic          out_last_q;

	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [7:0]    stack_rd_q;
	logic [6:0]    run_mem [MAX_RUN];
	logic [6:0]    run_rd_q;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          lit;
	logic          run_fail;
	logic          overflow;
	logic [TW-1:0] top_m1;
	logic [NW-1:0] n_nx;
	logic [NW-1:0] idx_nx;
	logic          st_we;
	logic          st_re;
	logic          run_we;
	logic          run_re;

	// handshake
	assign byte_in.ready = (state_q == S_IDLE);
	assign accept        = byte_in.valid && byte_in.ready;
	assign out_free      = !out_valid_q || text_out.ready;
	assign out_load      = out_free && ((state_q == S_RESULT) || (state_q == S_EMIT_WR));

	assign text_out.valid    = out_valid_q;
	assign text_out.out_byte = out_byte_q;
	assign text_out.status   = out_stat_q;
	assign text_out.last     = out_last_q;

	// a new file restarts at the header whatever the phase
	assign eff_phase = sof_q ? PH_HEADER : phase_q;

	// expansion step decode
	assign lit      = !c_q[7] && (c_q != 8'd0);
	assign run_fail = lit && (n_q == RUN_LIMIT);
	assign overflow = top_q > TOP_LIMIT;
	assign top_m1   = top_q - TW'(1);
	assign n_nx     = n_q + NW'(lit);
	assign idx_nx   = idx_q + NW'(1);

	// pair table requests
	always_comb begin
		tbl_req.clear = accept && byte_in.start_of_file;
		tbl_req.we    = (state_q == S_DISPATCH) && (eff_phase == PH_LOAD);
		tbl_req.waddr = load_idx_q;
		tbl_req.wdata = byte_q;
		tbl_req.re    = (state_q == S_EVAL) && c_q[7];
		tbl_req.raddr = c_q[bpd_pkg::PAIR_AW-1:0];
	end

	// the first byte of a pair is consumed at once; only the second is pushed
	assign st_we  = (state_q == S_PAIR) && !overflow;
	assign st_re  = (state_q == S_EVAL) && !c_q[7] && !run_fail && (top_q != '0);
	assign run_we = (state_q == S_EVAL) && lit && !run_fail;
	assign run_re = (state_q == S_EMIT_RD);

	// expansion stack
	always_ff @(posedge clk) begin
		if (st_we) begin
			stack_mem[top_q[SAW-1:0]] <= tbl_pair.second;
		end
		if (st_re) begin
			stack_rd_q <= stack_mem[top_m1[SAW-1:0]];
		end
	end

	// run buffer: holds data bytes until the expansion is known good
	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[n_q[BAW-1:0]] <= bpd_pkg::convert(c_q[6:0]);
		end
		if (run_re) begin
			run_rd_q <= run_mem[idx_q[BAW-1:0]];
		end
	end

	// main state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_HEADER;
			byte_q      <= 8'd0;
			sof_q       <= 1'b0;
			pair_left_q <= 8'd0;
			load_idx_q  <= 8'd0;
			c_q         <= 8'd0;
			top_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			res_byte_q  <= 7'd0;
			res_stat_q  <= bpd_pkg::STAT_DATA;
			out_valid_q <= 1'b0;
			out_byte_q  <= 7'd0;
			out_stat_q  <= bpd_pkg::STAT_DATA;
			out_last_q  <= 1'b0;
		end else begin
			// word held until taken, or a new one loaded
			out_valid_q <= out_load || (out_valid_q && !text_out.ready);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q  <= byte_in.in_byte;
						sof_q   <= byte_in.start_of_file;
						state_q <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					unique case (eff_phase)
						PH_HEADER: begin
							if (byte_q[7]) begin
								// pair count header: two bytes per entry follow
								pair_left_q <= {byte_q[6:0], 1'b0};
								load_idx_q  <= 8'd0;
								phase_q     <= (byte_q[6:0] != 7'd0) ? PH_LOAD : PH_DECODE;
								state_q     <= S_IDLE;
							end else if (byte_q == 8'd0) begin
								res_byte_q <= 7'd0;
								res_stat_q <= bpd_pkg::STAT_END;
								phase_q    <= PH_STOP;
								state_q    <= S_RESULT;
							end else begin
								// leading literal
								res_byte_q <= bpd_pkg::convert(byte_q[6:0]);
								res_stat_q <= bpd_pkg::STAT_DATA;
								phase_q    <= PH_DECODE;
								state_q    <= S_RESULT;
							end
						end
						PH_LOAD: begin
							load_idx_q  <= load_idx_q + 8'd1;
							pair_left_q <= pair_left_q - 8'd1;
							if (pair_left_q == 8'd1) begin
								phase_q <= PH_DECODE;
							end
							state_q <= S_IDLE;
						end
						PH_DECODE: begin
							if (byte_q == 8'd0) begin
								res_byte_q <= 7'd0;
								res_stat_q <= bpd_pkg::STAT_END;
								phase_q    <= PH_STOP;
								state_q    <= S_RESULT;
							end else begin
								c_q     <= byte_q;
								top_q   <= '0;
								n_q     <= '0;
								state_q <= S_EVAL;
							end
						end
						PH_STOP: begin
							state_q <= S_IDLE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				S_RESULT: begin
					// single status or literal word, always last
					if (out_free) begin
						out_byte_q  <= res_byte_q;
						out_stat_q  <= res_stat_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				S_EVAL: begin
					if (c_q[7]) begin
						state_q <= S_PAIR;
					end else if (run_fail) begin
						res_byte_q <= 7'd0;
						res_stat_q <= bpd_pkg::STAT_BAD;
						phase_q    <= PH_STOP;
						state_q    <= S_RESULT;
					end else begin
						n_q <= n_nx;
						if (top_q == '0) begin
							idx_q   <= '0;
							state_q <= (n_nx == '0) ? S_IDLE : S_EMIT_RD;
						end else begin
							top_q   <= top_m1;
							state_q <= S_POPW;
						end
					end
				end

				S_PAIR: begin
					if (overflow) begin
						res_byte_q <= 7'd0;
						res_stat_q <= bpd_pkg::STAT_BAD;
						phase_q    <= PH_STOP;
						state_q    <= S_RESULT;
					end else begin
						top_q   <= top_q + TW'(1);
						c_q     <= tbl_pair.first;
						state_q <= S_EVAL;
					end
				end

				S_POPW: begin
					c_q     <= stack_rd_q;
					state_q <= S_EVAL;
				end

				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end

				S_EMIT_WR: begin
					if (out_free) begin
						out_byte_q  <= run_rd_q;
						out_stat_q  <= bpd_pkg::STAT_DATA;
						out_last_q  <= (idx_nx == n_q);
						idx_q       <= idx_nx;
						state_q     <= (idx_nx == n_q) ? S_IDLE : S_EMIT_RD;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/byte_pair_text_decompressor_unit.sv
// Byte pair text decompressor: top level.
//
// byte_in takes one compressed file byte per word with start_of_file set on
// the first byte of each file; that word clears the pair table. A first byte
// above 127 announces a pair count whose bytes load the table; every later
// byte is a literal or a code that expands into text bytes.
// text_out gives one word per decoded byte (status 0), or a single end of
// text (status 1) or malformed (status 2) word; last marks the final word
// caused by an input byte. After end or malformed input the block drops
// bytes until the next start_of_file.
// Timing: byte_in is ready only between items. Header, load and dropped
// bytes pass the dispatch state; a leading literal or an end of text byte
// also passes the result state. A decoded byte passes dispatch and eval,
// plus a pair state per lookup, a pop state per stack pop and a read and
// a write state per output word: the expansion stack and the run buffer
// are single-port, registered-read memories, walked one entry per step.
// A stalled receiver holds the output register and the sequencer waits on
// it; no word is dropped. Reset returns the block to expecting a header with
// an empty pair table; no clearing pass is needed.
`timescale 1ns / 1ps
module byte_pair_text_decompressor_unit #(
	parameter int STACK_DEPTH = bpd_pkg::STACK_DEPTH_DEF,
	parameter int MAX_RUN     = bpd_pkg::MAX_RUN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bpd_in_if.sink    byte_in,
	bpd_out_if.source text_out
);

	bpd_pkg::tbl_req_t tbl_req;
	bpd_pkg::pair_t    tbl_pair;

	bpd_pair_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_pair (tbl_pair)
	);

	bpd_seq #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_RUN     (MAX_RUN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.text_out (text_out),
		.tbl_req  (tbl_req),
		.tbl_pair (tbl_pair)
	);

endmodule

FILE: rtl/core/bpd_checker.sv
// Port-level checks on the decompressor output, bound to the top level.
`timescale 1ns / 1ps
module bpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_byte,
	input logic [1:0] status,
	input logic       last
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
			&& $stable(last))
		else $error("output word changed while stalled");

	// status words stand alone
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != bpd_pkg::STAT_DATA) |-> last && (out_byte == 7'd0))
		else $error("status word not last or carries a byte");

	// zeros never emitted, CR and tab always rewritten
	a_data_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bpd_pkg::STAT_DATA) |->
			(out_byte != 7'd0) && (out_byte != bpd_pkg::CHAR_CR)
			&& (out_byte != bpd_pkg::CHAR_TAB))
		else $error("bad data byte on output");

	// only defined status codes
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == bpd_pkg::STAT_DATA) || (status == bpd_pkg::STAT_END)
			|| (status == bpd_pkg::STAT_BAD))
		else $error("undefined status code");

endmodule

bind byte_pair_text_decompressor_unit bpd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (text_out.valid),
	.out_ready (text_out.ready),
	.out_byte  (text_out.out_byte),
	.status    (text_out.status),
	.last      (text_out.last)
);
